/* hdl/pwli_pkg.sv */
package pwli_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Field widths
	localparam int ENTRY_IDX_W = 6;
	localparam int PTS_W       = 7;
	localparam int WAVE_W      = 16;
	localparam int VAL_W       = 32;

	// Interpolation fraction (unsigned 0.16)
	localparam int FRAC_W    = 16;
	localparam int DIV_CNT_W = $clog2(FRAC_W + 1);

	// Item function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK0,
		S_CHKN,
		S_SRCH,
		S_UP,
		S_LO,
		S_DIV,
		S_MUL,
		S_ADD,
		S_OUT
	} state_t;

	// Fraction divider handshake
	typedef struct packed {
		logic              start;
		logic [FRAC_W-1:0] num;
		logic [FRAC_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [FRAC_W-1:0] quot;
	} div_rsp_t;

endpackage

/* hdl/pwli_ram.sv */
module pwli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/pwli_div.sv */
module pwli_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pwli_pkg::div_req_t req,
	output pwli_pkg::div_rsp_t rsp
);

	logic [pwli_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           done_q;
	logic [pwli_pkg::FRAC_W-1:0]    rem_q;
	logic [pwli_pkg::FRAC_W-1:0]    quot_q;
	logic [pwli_pkg::FRAC_W-1:0]    den_q;
	logic [pwli_pkg::FRAC_W:0]      rem_sh;
	logic [pwli_pkg::FRAC_W:0]      rem_nx;
	logic                           ge;

	// Restoring step: one quotient bit per cycle, remainder stays below divisor
	always_comb begin
		rem_sh = {rem_q, 1'b0};
		ge     = (rem_sh >= {1'b0, den_q});
		rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && (cnt_q == pwli_pkg::DIV_CNT_W'(1));
			if (req.start) begin
				cnt_q <= pwli_pkg::DIV_CNT_W'(pwli_pkg::FRAC_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - pwli_pkg::DIV_CNT_W'(1);
			end
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			quot_q <= '0;
			den_q  <= req.den;
		end else if (cnt_q != '0) begin
			rem_q  <= rem_nx[pwli_pkg::FRAC_W-1:0];
			quot_q <= {quot_q[pwli_pkg::FRAC_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

/* hdl/piecewise_linear_table_interp.sv */
// Piecewise-linear lookup over a table of up to 64 breakpoints.
// Input channel (in_valid/in_ready): a load beat (func = 0) writes one
// wavelength/value pair into the table in the cycle it is accepted and gives
// no result. A query beat (func = 1) gives one result beat on the output
// channel (out_valid/out_ready) carrying interp_value.
// points_in_use is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// A query is worked on alone: the block reads the table memories once per
// cycle (first entry, last entry, one binary-search probe per cycle, at most
// 7 for 64 points, then the bracketing pair) and, to interpolate, runs a
// one-bit-per-cycle fraction divider, one multiply and one add. The block is
// ready for the next beat in the same cycle that out_valid rises. A load
// leaves the block idle and ready for the next beat.
// The finished result sits in an output register, so the next beat is taken
// while the result waits; a further query stalls at its end until the output
// register is free. Reset clears points_in_use and all control state; the
// table contents are undefined until loaded.
module piecewise_linear_table_interp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pwli_pkg::PTS_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [pwli_pkg::ENTRY_IDX_W-1:0]  entry_index,
	input  logic [pwli_pkg::WAVE_W-1:0]       entry_wavelength,
	input  logic signed [pwli_pkg::VAL_W-1:0] entry_value,
	input  logic [pwli_pkg::WAVE_W-1:0]       query_wavelength,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [pwli_pkg::VAL_W-1:0] interp_value
);

	pwli_pkg::state_t state_q, state_nx;

	logic [pwli_pkg::PTS_W-1:0]  points_in_use_q;
	logic [pwli_pkg::CNT_W-1:0]  n_in;
	logic [pwli_pkg::CNT_W-1:0]  n_q;
	logic [pwli_pkg::WAVE_W-1:0] q_q;
	logic [pwli_pkg::CNT_W-1:0]  first_q;
	logic [pwli_pkg::CNT_W-1:0]  count_q;
	logic [pwli_pkg::IDX_W-1:0]  up_q;
	logic [pwli_pkg::WAVE_W-1:0] w1_q;
	logic [pwli_pkg::VAL_W-1:0]  v1_q;
	logic [pwli_pkg::VAL_W-1:0]  v0_q;
	logic [pwli_pkg::FRAC_W-1:0] t_q;
	logic [pwli_pkg::VAL_W-1:0]  prod_q;
	logic [pwli_pkg::VAL_W-1:0]  res_q;
	logic                        out_valid_q;
	logic [pwli_pkg::VAL_W-1:0]  interp_value_q;

	// Memory ports
	logic                        wr_en;
	logic [pwli_pkg::IDX_W-1:0]  wr_addr;
	logic                        rd_en;
	logic [pwli_pkg::IDX_W-1:0]  rd_addr;
	logic [pwli_pkg::WAVE_W-1:0] wave_rd;
	logic [pwli_pkg::VAL_W-1:0]  val_rd;

	// Search step
	logic [pwli_pkg::CNT_W-1:0]  step;
	logic [pwli_pkg::CNT_W-1:0]  mid_cur;
	logic                        probe_lt;
	logic [pwli_pkg::CNT_W-1:0]  first_nx;
	logic [pwli_pkg::CNT_W-1:0]  count_nx;
	logic [pwli_pkg::CNT_W-1:0]  mid_nx;
	logic [pwli_pkg::CNT_W-1:0]  up_nx;

	// Interval arithmetic
	logic [pwli_pkg::WAVE_W-1:0]     diff;
	logic [pwli_pkg::WAVE_W-1:0]     delta;
	logic signed [pwli_pkg::VAL_W:0] dv;
	logic signed [pwli_pkg::VAL_W+pwli_pkg::FRAC_W+1:0] prod;

	logic                   out_free;
	logic                   q_acc;
	logic                   ld_acc;
	pwli_pkg::div_req_t     div_req;
	pwli_pkg::div_rsp_t     div_rsp;

	assign out_free = !out_valid_q || out_ready;
	assign q_acc    = in_valid && in_ready && (func == pwli_pkg::FUNC_QUERY);
	assign ld_acc   = in_valid && in_ready && (func == pwli_pkg::FUNC_LOAD);

	// Count in use, clamped to the table depth
	assign n_in = ({25'd0, points_in_use_q} > 32'(pwli_pkg::TABLE_DEPTH))
		? pwli_pkg::CNT_W'(pwli_pkg::TABLE_DEPTH)
		: pwli_pkg::CNT_W'(points_in_use_q);

	// Binary-search step on the probe read last cycle
	always_comb begin
		step     = count_q >> 1;
		mid_cur  = first_q + step;
		probe_lt = (wave_rd < q_q);
		if (probe_lt) begin
			first_nx = mid_cur + pwli_pkg::CNT_W'(1);
			count_nx = count_q - step - pwli_pkg::CNT_W'(1);
		end else begin
			first_nx = first_q;
			count_nx = step;
		end
		mid_nx = first_nx + (count_nx >> 1);
		if (first_nx == '0) begin
			up_nx = pwli_pkg::CNT_W'(1);
		end else if (first_nx >= n_q) begin
			up_nx = n_q - pwli_pkg::CNT_W'(1);
		end else begin
			up_nx = first_nx;
		end
	end

	// Lower breakpoint arrives on the read port in S_LO
	assign diff  = q_q - wave_rd;
	assign delta = w1_q - wave_rd;
	assign dv    = $signed({v1_q[pwli_pkg::VAL_W-1], v1_q})
		- $signed({v0_q[pwli_pkg::VAL_W-1], v0_q});
	assign prod  = dv * $signed({1'b0, t_q});

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			pwli_pkg::S_IDLE: begin
				if (q_acc) begin
					state_nx = (n_in == '0) ? pwli_pkg::S_OUT : pwli_pkg::S_CHK0;
				end
			end
			pwli_pkg::S_CHK0: begin
				state_nx = (q_q <= wave_rd) ? pwli_pkg::S_OUT : pwli_pkg::S_CHKN;
			end
			pwli_pkg::S_CHKN: begin
				state_nx = (q_q >= wave_rd) ? pwli_pkg::S_OUT : pwli_pkg::S_SRCH;
			end
			pwli_pkg::S_SRCH: begin
				if (count_nx == '0) begin
					state_nx = pwli_pkg::S_UP;
				end
			end
			pwli_pkg::S_UP: begin
				state_nx = (wave_rd == q_q) ? pwli_pkg::S_OUT : pwli_pkg::S_LO;
			end
			pwli_pkg::S_LO: begin
				if (w1_q <= wave_rd) begin
					state_nx = pwli_pkg::S_OUT;
				end else if ((q_q < wave_rd) || (diff >= delta)) begin
					state_nx = pwli_pkg::S_MUL;
				end else begin
					state_nx = pwli_pkg::S_DIV;
				end
			end
			pwli_pkg::S_DIV: begin
				if (div_rsp.done) begin
					state_nx = pwli_pkg::S_MUL;
				end
			end
			pwli_pkg::S_MUL: state_nx = pwli_pkg::S_ADD;
			pwli_pkg::S_ADD: state_nx = pwli_pkg::S_OUT;
			pwli_pkg::S_OUT: begin
				if (out_free) begin
					state_nx = pwli_pkg::S_IDLE;
				end
			end
			default: state_nx = pwli_pkg::S_IDLE;
		endcase
	end

	// Memory read address and divider start
	always_comb begin
		rd_en       = 1'b0;
		rd_addr     = '0;
		div_req     = '0;
		div_req.num = diff;
		div_req.den = delta;
		case (state_q)
			pwli_pkg::S_IDLE: begin
				rd_en = q_acc;
			end
			pwli_pkg::S_CHK0: begin
				rd_en   = 1'b1;
				rd_addr = pwli_pkg::IDX_W'(n_q - pwli_pkg::CNT_W'(1));
			end
			pwli_pkg::S_CHKN: begin
				rd_en   = 1'b1;
				rd_addr = pwli_pkg::IDX_W'(n_q >> 1);
			end
			pwli_pkg::S_SRCH: begin
				rd_en   = 1'b1;
				rd_addr = (count_nx != '0) ? pwli_pkg::IDX_W'(mid_nx)
					: pwli_pkg::IDX_W'(up_nx);
			end
			pwli_pkg::S_UP: begin
				rd_en   = 1'b1;
				rd_addr = up_q - pwli_pkg::IDX_W'(1);
			end
			pwli_pkg::S_LO: begin
				div_req.start = (state_nx == pwli_pkg::S_DIV);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign in_ready = (state_q == pwli_pkg::S_IDLE);

	// Load path: slots beyond the table are dropped
	assign wr_en   = ld_acc && ({26'd0, entry_index} < 32'(pwli_pkg::TABLE_DEPTH));
	assign wr_addr = pwli_pkg::IDX_W'(entry_index);

	pwli_ram #(
		.WIDTH(pwli_pkg::WAVE_W),
		.DEPTH(pwli_pkg::TABLE_DEPTH)
	) u_wave_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(entry_wavelength),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(wave_rd)
	);

	pwli_ram #(
		.WIDTH(pwli_pkg::VAL_W),
		.DEPTH(pwli_pkg::TABLE_DEPTH)
	) u_val_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(entry_value),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(val_rd)
	);

	pwli_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= pwli_pkg::S_IDLE;
			points_in_use_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				points_in_use_q <= cfg_wdata;
			end
			if ((state_q == pwli_pkg::S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Query datapath
	always_ff @(posedge clk) begin
		case (state_q)
			pwli_pkg::S_IDLE: begin
				q_q   <= query_wavelength;
				n_q   <= n_in;
				res_q <= '0;
			end
			pwli_pkg::S_CHK0: begin
				res_q <= val_rd;
			end
			pwli_pkg::S_CHKN: begin
				res_q   <= val_rd;
				first_q <= '0;
				count_q <= n_q;
			end
			pwli_pkg::S_SRCH: begin
				first_q <= first_nx;
				count_q <= count_nx;
				up_q    <= pwli_pkg::IDX_W'(up_nx);
			end
			pwli_pkg::S_UP: begin
				res_q <= val_rd;
				w1_q  <= wave_rd;
				v1_q  <= val_rd;
			end
			pwli_pkg::S_LO: begin
				res_q <= val_rd;
				v0_q  <= val_rd;
				t_q   <= (q_q < wave_rd) ? '0 : '1;
			end
			pwli_pkg::S_DIV: begin
				t_q <= div_rsp.quot;
			end
			pwli_pkg::S_MUL: begin
				prod_q <= prod[pwli_pkg::VAL_W+pwli_pkg::FRAC_W-1:pwli_pkg::FRAC_W];
			end
			pwli_pkg::S_ADD: begin
				res_q <= v0_q + prod_q;
			end
			pwli_pkg::S_OUT: begin
				if (out_free) begin
					interp_value_q <= res_q;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign interp_value = interp_value_q;

	// The divider only reports while the sequencer waits on it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == pwli_pkg::S_DIV))
		else $error("divider done outside divide state");

	// A search step always has entries left to probe
	a_srch_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pwli_pkg::S_SRCH) |-> (count_q != '0))
		else $error("search step with empty range");

	// Upper breakpoint lies strictly inside the table in use
	a_up_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pwli_pkg::S_UP) |->
		((up_q != '0) && ({1'b0, up_q} < n_q)))
		else $error("upper breakpoint out of range");

	// A query leaves idle only with a non-empty table or straight to output
	a_empty_query: assert property (@(posedge clk) disable iff (!arst_n)
		(q_acc && (n_in == '0)) |=> ((state_q == pwli_pkg::S_OUT) && (res_q == '0)))
		else $error("empty-table query not returning zero");

endmodule
